/* sv/sff_pkg.sv */
package sff_pkg;

  // Codes carried in the mode field of an input item.
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_SNAPSHOT = 3'd1;
  localparam logic [2:0] MODE_INTENT   = 3'd2;
  localparam logic [2:0] MODE_SEND     = 3'd3;
  localparam logic [2:0] MODE_FORGET   = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RESET_GAP  = 2'd0;
  localparam logic [1:0] REG_LATE_LIMIT = 2'd1;
  localparam logic [1:0] REG_OWN_SLOT   = 2'd2;

  localparam logic [31:0] RESET_GAP_INIT  = 32'd256;
  localparam logic [7:0]  LATE_LIMIT_INIT = 8'd12;
  localparam logic [7:0]  NO_SLOT         = 8'hff;
  localparam logic [31:0] NO_AGE          = 32'hffff_ffff;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SNAPSHOT,
    OP_INTENT,
    OP_SEND,
    OP_FORGET,
    OP_NONE
  } op_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic [31:0] reset_gap;
    logic [7:0]  late_limit;
    logic [7:0]  own_slot;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  slot;
    logic        slot_ok;
    logic        own;
    logic [31:0] frame;
  } cmd_t;

  // A frame is late when a previous frame is known, the new one is not
  // newer, and it lies less than the reset gap behind.
  function automatic logic is_late(input logic [31:0] prev, input logic [31:0] fr,
                                   input logic [31:0] gap);
    logic [31:0] back_dist;
    back_dist = prev - fr;
    return (prev != 32'd0) && (fr <= prev) && (back_dist < gap);
  endfunction

endpackage

/* sv/sff_front.sv */
module sff_front #(
  parameter int SLOT_COUNT = 16
) (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [2:0]    s_tuser,   // mode
  input  logic [39:0]   s_tdata,   // slot [7:0], frame [39:8]
  input  sff_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output sff_pkg::cmd_t cmd
);
  import sff_pkg::*;

  localparam logic [8:0] SLOT_LIM = 9'(SLOT_COUNT);

  logic [7:0] slot;

  assign slot     = s_tdata[7:0];
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    cmd.slot    = slot;
    cmd.frame   = s_tdata[39:8];
    cmd.slot_ok = {1'b0, slot} < SLOT_LIM;
    cmd.own     = slot == cfg.own_slot;
    case (s_tuser)
      MODE_TICK:     cmd.op = OP_TICK;
      MODE_SNAPSHOT: cmd.op = OP_SNAPSHOT;
      MODE_INTENT:   cmd.op = OP_INTENT;
      MODE_SEND:     cmd.op = OP_SEND;
      MODE_FORGET:   cmd.op = OP_FORGET;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

/* sv/sff_queue.sv */
module sff_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sff_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output sff_pkg::cmd_t pop_cmd
);
  import sff_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == DEPTH_CNT;
  assign q_valid = count != '0;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/sff_back.sv */
module sff_back #(
  parameter int SLOT_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  sff_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  sff_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata
);
  import sff_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  back_state_t state;
  back_state_t state_next;

  // Slot table: last intent frame and local frame at its arrival.
  logic [63:0]           table_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] entry_ok;
  logic [63:0]           rd_data;
  logic                  rd_ok;

  cmd_t        cur;
  logic [31:0] local_frame;
  logic [31:0] local_frame_next;
  logic [31:0] last_snapshot;
  logic [31:0] last_snapshot_next;
  logic [7:0]  late_run;
  logic [7:0]  late_run_next;

  logic [IDX_W-1:0] fetch_idx;
  logic [IDX_W-1:0] cur_idx;
  logic             done;
  logic             wr_entry;
  logic             clr_entry;
  logic [31:0]      prev_intent;
  logic [31:0]      arrival;
  logic [31:0]      arrival_next;
  logic [31:0]      stamp_arrival;
  logic [7:0]       run_inc;
  logic             acc;
  logic             ooo;
  logic             srst;
  logic             stamped;
  logic [31:0]      frame_out;
  logic [31:0]      age;

  assign fetch_idx   = q_cmd.slot[IDX_W-1:0];
  assign cur_idx     = cur.slot[IDX_W-1:0];
  assign prev_intent = rd_ok ? rd_data[63:32] : 32'd0;
  assign arrival     = rd_ok ? rd_data[31:0] : 32'd0;
  assign run_inc     = late_run + 8'd1;
  assign stamp_arrival = (local_frame != 32'd0) ? local_frame : 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_FETCH;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    done       = 1'b0;
    case (state)
      BK_FETCH: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!m_tvalid || m_tready) begin
          done       = 1'b1;
          state_next = BK_FETCH;
        end
      end
      default: state_next = BK_FETCH;
    endcase
  end

  always_comb begin
    local_frame_next   = local_frame;
    last_snapshot_next = last_snapshot;
    late_run_next      = late_run;
    arrival_next       = arrival;
    wr_entry           = 1'b0;
    clr_entry          = 1'b0;
    acc                = 1'b0;
    ooo                = 1'b0;
    srst               = 1'b0;
    stamped            = 1'b0;
    case (cur.op)
      OP_TICK: local_frame_next = local_frame + 32'd1;
      OP_SNAPSHOT: begin
        if (is_late(last_snapshot, cur.frame, cfg.reset_gap)) begin
          ooo = 1'b1;
          if (run_inc < cfg.late_limit) begin
            late_run_next = run_inc;
          end else begin
            srst               = 1'b1;
            late_run_next      = 8'd0;
            last_snapshot_next = cur.frame;
            acc                = 1'b1;
          end
        end else begin
          late_run_next      = 8'd0;
          last_snapshot_next = cur.frame;
          acc                = 1'b1;
        end
      end
      OP_INTENT: begin
        if (cur.slot_ok && !cur.own) begin
          if (is_late(prev_intent, cur.frame, cfg.reset_gap)) begin
            ooo = 1'b1;
          end else begin
            wr_entry     = 1'b1;
            arrival_next = stamp_arrival;
            acc          = 1'b1;
          end
        end
      end
      OP_SEND: begin
        if (cur.frame != 32'd0) begin
          stamped = 1'b1;
          if (cur.frame > local_frame) begin
            local_frame_next = cur.frame;
          end
        end
      end
      OP_FORGET: begin
        if (cur.slot_ok) begin
          clr_entry    = 1'b1;
          arrival_next = 32'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    frame_out = stamped ? cur.frame : local_frame_next;
    if (!cur.slot_ok || arrival_next == 32'd0) begin
      age = NO_AGE;
    end else if (local_frame_next >= arrival_next) begin
      age = local_frame_next - arrival_next;
    end else begin
      age = 32'd0;
    end
  end

  // Table read in the fetch cycle, write in the execute cycle, so the
  // next item always sees this one's update.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_cmd;
      rd_data <= table_mem[fetch_idx];
    end
    if (done && wr_entry) begin
      table_mem[cur_idx] <= {cur.frame, stamp_arrival};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok      <= '0;
      rd_ok         <= 1'b0;
      local_frame   <= 32'd0;
      last_snapshot <= 32'd0;
      late_run      <= 8'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (pop) begin
        rd_ok <= entry_ok[fetch_idx];
      end
      if (done) begin
        local_frame   <= local_frame_next;
        last_snapshot <= last_snapshot_next;
        late_run      <= late_run_next;
        if (wr_entry) begin
          entry_ok[cur_idx] <= 1'b1;
        end else if (clr_entry) begin
          entry_ok[cur_idx] <= 1'b0;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {5'd0, age, frame_out, srst, ooo, acc};
    end
  end

endmodule

/* sv/stale_frame_filter.sv */
// Staleness filter for frame-numbered messages. Each input item (tuser holds
// the mode: tick, snapshot, remote intent, local send, forget slot) yields
// exactly one result item with the accept, late and stream-reset flags, the
// frame stamp and the intent age of the named slot. Items enter a two-entry
// command queue at one per cycle while it has room; the execution unit takes
// each item through a fetch state that reads the slot table, then an execute
// state that updates the state, loads the output register and waits while
// an untaken result holds it; only then is the next item fetched. The slot
// table needs no clearing pass: a per-slot valid bit, cleared by reset,
// makes an unwritten slot read as empty. The user must write configuration
// through the APB port only while no item is in flight; nothing checks it.
module stale_frame_filter #(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // mode
  input  logic [39:0] s_tdata,   // slot [7:0], frame [39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // accepted [0], out_of_order [1], stream_reset [2],
                                 // frame_out [34:3], intent_age [66:35], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sff_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_gap  <= RESET_GAP_INIT;
      cfg.late_limit <= LATE_LIMIT_INIT;
      cfg.own_slot   <= NO_SLOT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RESET_GAP:  cfg.reset_gap  <= pwdata;
        REG_LATE_LIMIT: cfg.late_limit <= pwdata[7:0];
        REG_OWN_SLOT:   cfg.own_slot   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RESET_GAP:  prdata = cfg.reset_gap;
      REG_LATE_LIMIT: prdata = {24'd0, cfg.late_limit};
      REG_OWN_SLOT:   prdata = {24'd0, cfg.own_slot};
      default:        prdata = 32'd0;
    endcase
  end

  sff_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push),
    .cmd     (push_cmd)
  );

  sff_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .pop_cmd (pop_cmd)
  );

  sff_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

/* verif/testbench.sv */
module testbench;
  import sff_pkg::*;

  localparam int SLOTS = 16;
  localparam int IDLE_PCT = 16;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_PER_SETTING = 250;
  // The mode field is three bits wide; codes above MODE_FORGET are unused.
  localparam logic [2:0] MODE_LAST = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  slot;
    logic [31:0] frame;
  } frame_msg_t;

  typedef struct packed {
    logic        accepted;
    logic        out_of_order;
    logic        stream_reset;
    logic [31:0] frame_out;
    logic [31:0] intent_age;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [2:0]  s_tuser = MODE_TICK;
  logic [39:0] s_tdata = '0;     // slot [7:0], frame [39:8]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // accepted [0], out_of_order [1], stream_reset [2],
                                 // frame_out [34:3], intent_age [66:35]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stale_frame_filter #(.SLOT_COUNT(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted configuration and filter state.
  logic [31:0] gap_cfg = RESET_GAP_INIT;
  logic [7:0]  limit_cfg = LATE_LIMIT_INIT;
  logic [7:0]  own_cfg = NO_SLOT;
  logic [31:0] clock_frame = '0;
  logic [31:0] snap_frame = '0;
  logic [7:0]  late_count = '0;
  logic [31:0] intent_frame [SLOTS] = '{default: '0};
  logic [31:0] intent_arrival_at [SLOTS] = '{default: '0};

  frame_msg_t outgoing_items [$];
  verdict_t   expected_verdicts [$];

  bit in_taken = 1'b0;
  bit calm = 1'b0;
  bit want_hold = 1'b0;
  bit hold_served = 1'b0;
  int hold_left = 0;
  int fails = 0;
  int items_in = 0;
  int verdicts_checked = 0;
  int late_hits = 0;
  int forced_resets = 0;
  int settings_run = 0;

  // Stimulus generator state.
  logic [31:0] frame_base = 32'd1000;
  logic [31:0] last_snap_sent = '0;

  function automatic bit late_against(logic [31:0] prev, logic [31:0] fr);
    return prev != '0 && fr <= prev && (prev - fr) < gap_cfg;
  endfunction

  function automatic verdict_t filter_item(frame_msg_t it);
    verdict_t   v;
    bit         slot_ok;
    bit         stamped;
    logic [3:0] idx;
    v = '0;
    stamped = 1'b0;
    slot_ok = it.slot < SLOTS;
    idx = it.slot[3:0];
    case (it.mode)
      MODE_TICK: clock_frame = clock_frame + 32'd1;
      MODE_SNAPSHOT: begin
        if (late_against(snap_frame, it.frame)) begin
          v.out_of_order = 1'b1;
          late_count = late_count + 8'd1;
          if (late_count >= limit_cfg) v.stream_reset = 1'b1;
        end
        if (!v.out_of_order || v.stream_reset) begin
          late_count = '0;
          snap_frame = it.frame;
          v.accepted = 1'b1;
        end
      end
      MODE_INTENT: begin
        if (slot_ok && it.slot != own_cfg) begin
          if (late_against(intent_frame[idx], it.frame)) begin
            v.out_of_order = 1'b1;
          end else begin
            intent_frame[idx] = it.frame;
            intent_arrival_at[idx] = (clock_frame != '0) ? clock_frame : 32'd1;
            v.accepted = 1'b1;
          end
        end
      end
      MODE_SEND: begin
        if (it.frame != '0) begin
          if (it.frame > clock_frame) clock_frame = it.frame;
          stamped = 1'b1;
        end
      end
      MODE_FORGET: begin
        if (slot_ok) begin
          intent_frame[idx] = '0;
          intent_arrival_at[idx] = '0;
        end
      end
      default: ;
    endcase
    v.frame_out = stamped ? it.frame : clock_frame;
    if (!slot_ok || intent_arrival_at[idx] == '0) begin
      v.intent_age = NO_AGE;
    end else if (clock_frame >= intent_arrival_at[idx]) begin
      v.intent_age = clock_frame - intent_arrival_at[idx];
    end else begin
      v.intent_age = '0;
    end
    return v;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // Input acceptance, prediction and result checking, all on the rising edge.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_verdicts.push_back(filter_item({s_tuser, s_tdata[7:0], s_tdata[39:8]}));
        if (expected_verdicts[$].out_of_order) late_hits++;
        if (expected_verdicts[$].stream_reset) forced_resets++;
        void'(outgoing_items.pop_front());
        in_taken = 1'b1;
        items_in++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result item with no expectation waiting: %h", m_tdata);
          fails++;
        end else begin
          verdict_t want;
          want = expected_verdicts.pop_front();
          verdicts_checked++;
          if (m_tdata[0] !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, m_tdata[0]);
            fails++;
          end
          if (m_tdata[1] !== want.out_of_order) begin
            $error("out_of_order: expected %0d, got %0d", want.out_of_order, m_tdata[1]);
            fails++;
          end
          if (m_tdata[2] !== want.stream_reset) begin
            $error("stream_reset: expected %0d, got %0d", want.stream_reset, m_tdata[2]);
            fails++;
          end
          if (m_tdata[34:3] !== want.frame_out) begin
            $error("frame_out: expected %h, got %h", want.frame_out, m_tdata[34:3]);
            fails++;
          end
          if (m_tdata[66:35] !== want.intent_age) begin
            $error("intent_age: expected %h, got %h", want.intent_age, m_tdata[66:35]);
            fails++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (outgoing_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tuser <= outgoing_items[0].mode;
        s_tdata <= {outgoing_items[0].frame, outgoing_items[0].slot};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // The receiver owns its long hold-off count so the input side keeps offering.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_served) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_served <= 1'b1;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RESET_GAP:  gap_cfg = value;
      REG_LATE_LIMIT: limit_cfg = value[7:0];
      REG_OWN_SLOT:   own_cfg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (outgoing_items.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] gap, input logic [7:0] limit,
                               input logic [7:0] own);
    settle();
    write_reg(REG_RESET_GAP, gap);
    write_reg(REG_LATE_LIMIT, {24'd0, limit});
    write_reg(REG_OWN_SLOT, {24'd0, own});
    @(posedge clk);
    settings_run++;
  endtask

  task automatic queue_item(input logic [2:0] mode, input logic [7:0] slot,
                            input logic [31:0] frame);
    outgoing_items.push_back('{mode: mode, slot: slot, frame: frame});
    if (mode == MODE_SNAPSHOT) last_snap_sent = frame;
  endtask

  function automatic logic [31:0] pick_frame();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 8) return '1;
    if (roll < 14) return $urandom();
    frame_base = frame_base + $urandom_range(0, 6);
    if (roll < 40) return frame_base - $urandom_range(0, 40);
    return frame_base + $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, SLOTS - 1));
    return 8'($urandom_range(SLOTS, 255));
  endfunction

  task automatic random_items(input int count);
    int          sent;
    int unsigned roll;
    int          run;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        // A run of repeated or slightly older snapshots drives the late counter.
        run = $urandom_range(3, 20);
        repeat (run) queue_item(MODE_SNAPSHOT, pick_slot(),
                                last_snap_sent - $urandom_range(0, 2));
        sent += run;
      end else begin
        if (roll < 22) queue_item(MODE_TICK, pick_slot(), pick_frame());
        else if (roll < 50) queue_item(MODE_SNAPSHOT, pick_slot(), pick_frame());
        else if (roll < 76) queue_item(MODE_INTENT, pick_slot(), pick_frame());
        else if (roll < 87) queue_item(MODE_SEND, pick_slot(),
                                       ($urandom_range(0, 2) == 0) ? '0 : pick_frame());
        else if (roll < 96) queue_item(MODE_FORGET, pick_slot(), pick_frame());
        else queue_item(3'($urandom_range(MODE_FORGET + 1, MODE_LAST)), pick_slot(),
                        pick_frame());
        sent++;
      end
    end
  endtask

  initial begin
    int m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    settings_run = 1;

    // Directed opening under the reset settings.
    queue_item(MODE_INTENT, 8'd0, 32'd7);         // arrival clamps to one at frame zero
    queue_item(MODE_SNAPSHOT, 8'd0, 32'd0);
    queue_item(MODE_SNAPSHOT, 8'd0, 32'd100);
    queue_item(MODE_SNAPSHOT, 8'd0, 32'd100);     // equal frame is late
    queue_item(MODE_SNAPSHOT, 8'd0, 32'd50);
    queue_item(MODE_SNAPSHOT, 8'd0, 32'hffff_ffff);
    queue_item(MODE_SNAPSHOT, 8'd0, 32'hffff_ff01);
    queue_item(MODE_SNAPSHOT, 8'd0, 32'hffff_0000); // far behind, not late
    queue_item(MODE_TICK, 8'd0, 32'd0);
    queue_item(MODE_TICK, 8'd0, 32'd0);
    queue_item(MODE_INTENT, 8'd3, 32'd10);
    queue_item(MODE_INTENT, 8'd3, 32'd10);
    queue_item(MODE_INTENT, 8'd15, 32'hffff_ffff);
    queue_item(MODE_INTENT, 8'd16, 32'd5);
    queue_item(MODE_INTENT, 8'd255, 32'd5);
    queue_item(MODE_SEND, 8'd3, 32'd0);
    queue_item(MODE_SEND, 8'd3, 32'd1000);
    queue_item(MODE_SEND, 8'd15, 32'd5);          // stamped below the counter
    queue_item(MODE_FORGET, 8'd3, 32'd0);
    queue_item(MODE_FORGET, 8'd200, 32'd0);
    queue_item(MODE_TICK, 8'd3, 32'd0);
    for (m = MODE_FORGET + 1; m <= MODE_LAST; m++) queue_item(3'(m), 8'd0, 32'hffff_ffff);
    queue_item(MODE_SEND, 8'd0, 32'hffff_ffff);
    queue_item(MODE_TICK, 8'd0, 32'd0);           // counter wraps, arrival now ahead
    queue_item(MODE_INTENT, 8'd1, 32'd3);
    random_items(RANDOM_PER_SETTING);

    apply_setting(32'd1, 8'd1, 8'd0);
    want_hold = 1'b1;
    random_items(RANDOM_PER_SETTING);

    apply_setting(32'd0, 8'd0, 8'd15);
    calm = 1'b1;
    random_items(RANDOM_PER_SETTING);

    apply_setting(32'hffff_ffff, 8'd255, 8'd16);
    calm = 1'b0;
    random_items(RANDOM_PER_SETTING);

    apply_setting(32'd16, 8'd3, 8'd5);
    random_items(RANDOM_PER_SETTING);

    apply_setting(32'd1000, 8'd12, 8'd255);
    random_items(RANDOM_PER_SETTING);

    settle();
    if (expected_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", expected_verdicts.size());
      fails++;
    end
    $display("%0d items sent and %0d results checked over %0d register settings",
             items_in, verdicts_checked, settings_run);
    $display("%0d late items and %0d forced stream resets predicted", late_hits, forced_resets);
    if (fails == 0) begin
      $display("stale_frame_filter regression: pass");
    end else begin
      $display("stale_frame_filter regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("stale_frame_filter regression: fail");
    $finish;
  end

endmodule
